### hdl/tvln_pkg.sv
// Shared types and constants for the text view line numberer.
// Holds the register map, the queue entry format and the character codes.
// Depends on nothing; the front, back, top level and checker import it.
package tvln_pkg;

	// Default width of the line number field, in decimal digits.
	localparam int DefLineDigits = 6;
	// Entries of the queue between front and back.
	localparam int FifoDepth = 4;
	// Longest displayed form of one input byte ("M-^X").
	localparam int BodyMax = 4;
	localparam int BodyIdxW = $clog2(BodyMax);

	localparam int CfgIndexW = 3;
	localparam int CfgDataW = 1;

	typedef enum logic [CfgIndexW-1:0] {
		REG_NUMBER_ALL       = 3'd0,
		REG_NUMBER_NONBLANK  = 3'd1,
		REG_SQUEEZE_BLANK    = 3'd2,
		REG_SHOW_ENDS        = 3'd3,
		REG_SHOW_TABS        = 3'd4,
		REG_SHOW_NONPRINTING = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic number_all;
		logic number_nonblank;
		logic squeeze_blank;
		logic show_ends;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_NUMBER,
		PFX_PAD
	} pfx_kind_t;

	// One queue entry without the line number: prefix kind, last body index and
	// body bytes, first body byte in the lowest bits.
	typedef struct packed {
		pfx_kind_t             pfx;
		logic [BodyIdxW-1:0]   last_idx;
		logic [BodyMax*8-1:0]  body;
	} desc_t;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_CAP_I  = 8'h49;
	localparam logic [7:0] CH_CAP_M  = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
	localparam logic [7:0] CH_META_LO  = 8'h80;
	localparam logic [7:0] CH_META_HI  = 8'h9F;
	localparam logic [7:0] CARET_OFFSET = 8'h40;

endpackage

### hdl/tvln_front.sv
// Front end of the text view line numberer: accepts input words, tracks line
// and blank-run state, keeps the BCD line counter and writes queue entries.
// Depends on tvln_pkg.
module tvln_front #(
	parameter int LINE_DIGITS = tvln_pkg::DefLineDigits
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tvln_pkg::cfg_t             cfg,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_byte,
	input  logic                       s_first,
	input  logic                       q_full,
	output logic                       q_push,
	output tvln_pkg::desc_t            q_desc,
	output logic [LINE_DIGITS*4-1:0]   q_num
);
	import tvln_pkg::*;

	localparam int NumW = LINE_DIGITS * 4;

	logic            prev_nl_q;
	logic [1:0]      blank_run_q;
	logic            drop_q;
	logic [NumW-1:0] bcd_q;

	logic            prev_nl_e, drop_e;
	logic [1:0]      blank_run_e, blank_run_n;
	logic [NumW-1:0] bcd_e;
	logic            is_nl, caret, accept, emit;
	logic            prev_nl_d, drop_d;
	logic [1:0]      blank_run_d;
	logic [NumW-1:0] bcd_d;
	pfx_kind_t       pfx;
	logic [BodyIdxW-1:0]  last_idx;
	logic [BodyMax*8-1:0] body;

	// Increment with saturation at all nines.
	function automatic logic [NumW-1:0] bcd_inc(input logic [NumW-1:0] v);
		logic [NumW-1:0] r;
		logic carry;
		logic nines;
		r = v;
		carry = 1'b1;
		nines = 1'b1;
		for (int i = 0; i < LINE_DIGITS; i++) begin
			if (v[i*4 +: 4] != 4'd9) nines = 1'b0;
		end
		for (int i = 0; i < LINE_DIGITS; i++) begin
			if (carry) begin
				if (v[i*4 +: 4] < 4'd9) begin
					r[i*4 +: 4] = v[i*4 +: 4] + 4'd1;
					carry = 1'b0;
				end else begin
					r[i*4 +: 4] = 4'd0;
				end
			end
		end
		if (nines) r = v;
		return r;
	endfunction

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_nl    = (s_byte == CH_NL);
	assign caret    = cfg.show_nonprinting || cfg.show_ends || cfg.show_tabs;

	// A new file restarts the state before the byte is looked at.
	always_comb begin
		prev_nl_e   = s_first ? 1'b1 : prev_nl_q;
		blank_run_e = s_first ? 2'd0 : blank_run_q;
		drop_e      = s_first ? 1'b0 : drop_q;
		bcd_e       = s_first ? NumW'(1) : bcd_q;
	end

	assign blank_run_n = (is_nl && prev_nl_e) ?
		((blank_run_e == 2'd3) ? 2'd3 : blank_run_e + 2'd1) : 2'd0;

	always_comb begin
		prev_nl_d   = prev_nl_e;
		blank_run_d = blank_run_e;
		drop_d      = drop_e;
		bcd_d       = bcd_e;
		pfx         = PFX_NONE;
		emit        = 1'b0;
		if (drop_e && is_nl) begin
			emit = 1'b0;
		end else if (cfg.squeeze_blank && blank_run_n > 2'd1) begin
			drop_d      = 1'b1;
			blank_run_d = 2'd0;
		end else begin
			emit        = 1'b1;
			drop_d      = 1'b0;
			blank_run_d = blank_run_n;
			prev_nl_d   = is_nl;
			if (prev_nl_e) begin
				if ((cfg.number_nonblank && blank_run_n == 2'd0) ||
				    (cfg.number_all && !cfg.number_nonblank)) begin
					pfx   = PFX_NUMBER;
					bcd_d = bcd_inc(bcd_e);
				end else if (cfg.number_nonblank && cfg.show_ends) begin
					pfx = PFX_PAD;
				end
			end
		end
	end

	// Displayed form of the byte itself.
	always_comb begin
		body     = '0;
		last_idx = '0;
		priority if (is_nl) begin
			if (cfg.show_ends) begin
				body[15:0] = {CH_NL, CH_DOLLAR};
				last_idx   = BodyIdxW'(1);
			end else begin
				body[7:0] = s_byte;
			end
		end else if (s_byte == CH_TAB) begin
			if (cfg.show_tabs) begin
				body[15:0] = {CH_CAP_I, CH_CARET};
				last_idx   = BodyIdxW'(1);
			end else begin
				body[7:0] = s_byte;
			end
		end else if (caret && s_byte <= CH_CTRL_MAX) begin
			body[15:0] = {s_byte + CARET_OFFSET, CH_CARET};
			last_idx   = BodyIdxW'(1);
		end else if (caret && s_byte == CH_DEL) begin
			body[15:0] = {CH_QUEST, CH_CARET};
			last_idx   = BodyIdxW'(1);
		end else if (caret && s_byte >= CH_META_LO && s_byte <= CH_META_HI) begin
			body[31:0] = {s_byte - CARET_OFFSET, CH_CARET, CH_DASH, CH_CAP_M};
			last_idx   = BodyIdxW'(3);
		end else begin
			body[7:0] = s_byte;
		end
	end

	assign q_push        = accept && emit;
	assign q_desc.pfx    = pfx;
	assign q_desc.last_idx = last_idx;
	assign q_desc.body   = body;
	assign q_num         = bcd_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_nl_q   <= 1'b1;
			blank_run_q <= 2'd0;
			drop_q      <= 1'b0;
			bcd_q       <= NumW'(1);
		end else if (accept) begin
			prev_nl_q   <= prev_nl_d;
			blank_run_q <= blank_run_d;
			drop_q      <= drop_d;
			bcd_q       <= bcd_d;
		end
	end

endmodule

### hdl/tvln_fifo.sv
// Small register queue between the front and back of the line numberer.
// Generic width and depth; no package types are used.
// Depends on nothing else in the block.
module tvln_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			if (do_push && !do_pop) count_q <= count_q + CntW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
		end
	end

endmodule

### hdl/tvln_back.sv
// Back end of the line numberer: walks the queue head entry (prefix digits
// or pad, tab, body) into the output register, one output byte per cycle
// while the output is not stalled. Depends on tvln_pkg.
module tvln_back #(
	parameter int LINE_DIGITS = tvln_pkg::DefLineDigits
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  tvln_pkg::desc_t            q_desc,
	input  logic [LINE_DIGITS*4-1:0]   q_num,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,
	output logic                       m_tlast
);
	import tvln_pkg::*;

	localparam int PosW = $clog2(LINE_DIGITS + 1 + BodyMax);
	localparam int DigW = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1;
	localparam logic [PosW-1:0] PfxLen   = PosW'(LINE_DIGITS + 1);
	localparam logic [PosW-1:0] TabPos   = PosW'(LINE_DIGITS);

	logic [PosW-1:0] pos_q;
	logic            valid_q, last_q;
	logic [7:0]      data_q;

	logic [3:0]      dig  [LINE_DIGITS];
	logic            lead [LINE_DIGITS];
	logic            has_pfx, in_pfx, is_last, load;
	logic [PosW-1:0] body_pos;
	logic [BodyIdxW-1:0] bidx;
	logic [7:0]      cur_byte;

	// Digits most significant first; leading zeros show as spaces.
	always_comb begin
		logic zeros;
		zeros = 1'b1;
		for (int j = 0; j < LINE_DIGITS; j++) begin
			dig[j]  = q_num[(LINE_DIGITS-1-j)*4 +: 4];
			zeros   = zeros && (dig[j] == 4'd0) && (j != LINE_DIGITS - 1);
			lead[j] = zeros;
		end
	end

	assign has_pfx  = (q_desc.pfx != PFX_NONE);
	assign in_pfx   = has_pfx && (pos_q < PfxLen);
	assign body_pos = has_pfx ? (pos_q - PfxLen) : pos_q;
	assign bidx     = body_pos[BodyIdxW-1:0];
	assign is_last  = !in_pfx && (bidx == q_desc.last_idx);

	always_comb begin
		if (in_pfx) begin
			if (pos_q == TabPos) begin
				cur_byte = CH_TAB;
			end else if (q_desc.pfx == PFX_PAD || lead[pos_q[DigW-1:0]]) begin
				cur_byte = CH_SPACE;
			end else begin
				cur_byte = CH_ZERO + {4'd0, dig[pos_q[DigW-1:0]]};
			end
		end else begin
			cur_byte = q_desc.body[bidx*8 +: 8];
		end
	end

	assign load  = !q_empty && (!valid_q || m_tready);
	assign q_pop = load && is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= cur_byte;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				pos_q   <= is_last ? '0 : pos_q + PosW'(1);
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

### hdl/text_view_line_numberer.sv
// Text view line numberer: a byte stream display filter that adds line
// numbers, end marks and caret notation and squeezes blank runs. One input
// word is taken per clock cycle as long as the internal queue has room; each
// input byte yields from zero up to LINE_DIGITS+5 output words, and the output
// side moves at most one word per cycle. The output byte rate therefore sets
// the sustained pace: a plain byte costs one output word, an expanded byte
// (number prefix, "$", "^X", "M-^X") costs every word that it prints, and
// a four-entry queue between the classifying front and the byte-emitting back
// absorbs those bursts while the input keeps flowing. Input bytes that print
// nothing (squeezed newlines) take no queue slot. There is no clearing pass
// after reset; the input is ready as soon as reset is released.
// Depends on tvln_pkg, tvln_front, tvln_fifo and tvln_back.
module text_view_line_numberer #(
	parameter int LINE_DIGITS = tvln_pkg::DefLineDigits
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [tvln_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [tvln_pkg::CfgDataW-1:0]  cfg_data,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] data_byte
	input  logic                           s_tuser,  // [0] first_of_file
	// Output stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,  // [7:0] out_byte
	output logic                           m_tlast   // last_of_run
);
	import tvln_pkg::*;

	localparam int NumW  = LINE_DIGITS * 4;
	localparam int DescW = $bits(desc_t);

	cfg_t            cfg_q;
	logic            q_push, q_pop, q_full, q_empty;
	desc_t           push_desc, head_desc;
	logic [NumW-1:0] push_num, head_num;
	logic [NumW+DescW-1:0] head_word;

	// Configuration registers; writes to unused indexes fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data[0];
				REG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data[0];
				REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data[0];
				REG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data[0];
				REG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data[0];
				REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The front decides what a byte prints and snapshots the line number
	// that goes with it, so the counter can move on before the back is done.
	tvln_front #(
		.LINE_DIGITS(LINE_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_byte   (s_tdata),
		.s_first  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_desc   (push_desc),
		.q_num    (push_num)
	);

	tvln_fifo #(
		.WIDTH(NumW + DescW),
		.DEPTH(FifoDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data ({push_num, push_desc}),
		.pop     (q_pop),
		.rd_data (head_word),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign head_desc = head_word[DescW-1:0];
	assign head_num  = head_word[NumW+DescW-1:DescW];

	// The back spells out the head entry, one byte per accepted output word.
	tvln_back #(
		.LINE_DIGITS(LINE_DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_desc   (head_desc),
		.q_num    (head_num),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### hdl/tvln_checker.sv
// Port-level checks for the text view line numberer, bound to the top level.
// Watches only the output stream; depends on tvln_pkg.
module tvln_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);
	import tvln_pkg::*;

	logic out_acc;
	logic caret_q, dash_q, meta_q;

	assign out_acc = m_tvalid && m_tready;

	// Track the open caret and meta sequences in the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			caret_q <= 1'b0;
			dash_q  <= 1'b0;
			meta_q  <= 1'b0;
		end else if (out_acc) begin
			caret_q <= (m_tdata == CH_CARET) && !m_tlast;
			dash_q  <= (m_tdata == CH_DASH) && !m_tlast;
			meta_q  <= (m_tdata == CH_CAP_M) && !m_tlast;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_caret_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && caret_q |-> m_tlast && m_tdata >= CH_QUEST && m_tdata <= 8'h5F)
		else $error("caret not followed by its final character");

	a_meta_dash: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && meta_q |-> m_tdata == CH_DASH && !m_tlast)
		else $error("meta prefix broken after M");

	a_dash_caret: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && dash_q |-> m_tdata == CH_CARET && !m_tlast)
		else $error("meta prefix broken after dash");

endmodule

bind text_view_line_numberer tvln_checker u_tvln_checker (.*);
